// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the pedal plausibility RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset
`define PPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define PPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ppm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppm_pkg
// Types and codes shared by the pedal plausibility monitor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ppm_pkg;

  // Sensor status
  typedef enum logic [1:0] {
    ST_INIT   = 2'd0,
    ST_NORMAL = 2'd1,
    ST_ERR    = 2'd2
  } status_e;

  // Active / requested error
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_IO    = 2'd1,
    ERR_PLAUS = 2'd2
  } err_e;

  // Event source
  localparam logic SRC_ACCEL = 1'b0;
  localparam logic SRC_BRAKE = 1'b1;

  // Event opcodes (any other code only re-evaluates)
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_ERROR  = 2'd1;

  // Result kinds
  localparam logic [1:0] KIND_REPORT  = 2'd0;
  localparam logic [1:0] KIND_ASSERT  = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // Error kind reported with assert / release
  localparam logic EK_IO    = 1'b0;
  localparam logic EK_PLAUS = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_PEDAL_MIN = 2'd0;
  localparam logic [1:0] CFG_PEDAL_MAX = 2'd1;
  localparam logic [1:0] CFG_ON_PCT    = 2'd2;
  localparam logic [1:0] CFG_OFF_PCT   = 2'd3;

  // Percentage registers
  localparam int unsigned PCT_W = 7;
  localparam logic [PCT_W-1:0] ON_PCT_RESET  = 7'd25;
  localparam logic [PCT_W-1:0] OFF_PCT_RESET = 7'd5;
  localparam int PEDAL_MAX_RESET = 32767;

  // Monitor control state
  typedef struct packed {
    status_e accel;
    status_e brake;
    err_e    active;
    logic    brake_pressed;
    logic    latched;
    logic    last_valid;
  } ppm_flags_t;

  // Result control fields (throttle travels separately)
  typedef struct packed {
    logic [1:0] kind;
    logic       error_kind;
    logic       last;
  } ppm_res_t;

endpackage

`default_nettype wire

// ===== rtl/ppm_eval.sv =====
// ----------------------------------------------------------------------------
// ppm_eval
// Single-pass evaluation of one pedal event: status update, plausibility
// latch with hysteresis, error assert/release and throttle report.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_eval #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                         src_i,
  input  logic [1:0]                   op_i,
  input  logic signed [VALUE_BITS-1:0] sample_i,
  input  logic                         err_flag_i,
  input  logic signed [VALUE_BITS-1:0] pedal_min_i,
  input  logic signed [VALUE_BITS-1:0] pedal_max_i,
  input  logic [ppm_pkg::PCT_W-1:0]    on_pct_i,
  input  logic [ppm_pkg::PCT_W-1:0]    off_pct_i,
  input  ppm_pkg::ppm_flags_t          flags_i,
  input  logic signed [VALUE_BITS-1:0] thr_i,
  input  logic signed [VALUE_BITS-1:0] last_rep_i,
  output ppm_pkg::ppm_flags_t          flags_o,
  output logic signed [VALUE_BITS-1:0] thr_o,
  output logic signed [VALUE_BITS-1:0] last_rep_o,
  output logic [1:0]                   res_cnt_o,
  output ppm_pkg::ppm_res_t            res_o [2],
  output logic signed [VALUE_BITS-1:0] res_thr_o [2]
);
  import ppm_pkg::*;

  // Compare width: 100*throttle and range*pct+99 both fit
  localparam int unsigned CW = VALUE_BITS + 9;
  localparam logic signed [CW-1:0] HUNDRED     = CW'(100);
  localparam logic signed [CW-1:0] NINETY_NINE = CW'(99);

  ppm_flags_t                   flags_u;
  logic signed [VALUE_BITS-1:0] thr_u;
  logic signed [VALUE_BITS:0]   range_w;
  logic signed [VALUE_BITS+7:0] prod_w;
  logic signed [CW-1:0]         prod_x;
  logic signed [CW-1:0]         t100;
  logic [PCT_W-1:0]             pct_sel;
  logic                         above_th;

  ppm_flags_t                   flags;
  logic signed [VALUE_BITS-1:0] lrep;
  logic [1:0]                   cnt;
  logic                         run;
  logic                         io;
  err_e                         req;

  // Apply the event to sensor status and readings
  always_comb begin
    flags_u = flags_i;
    thr_u   = thr_i;
    if (op_i == OP_SAMPLE) begin
      unique case (src_i)
        SRC_ACCEL: begin
          flags_u.accel = ST_NORMAL;
          thr_u         = sample_i;
        end
        SRC_BRAKE: begin
          flags_u.brake         = ST_NORMAL;
          flags_u.brake_pressed = (sample_i > 0);
        end
        default: ;
      endcase
    end else if ((op_i == OP_ERROR) && err_flag_i) begin
      unique case (src_i)
        SRC_ACCEL: flags_u.accel = ST_ERR;
        SRC_BRAKE: flags_u.brake = ST_ERR;
        default: ;
      endcase
    end
  end

  // Threshold test: throttle > trunc(range*pct/100), done without a divider.
  // Non-negative product: t > P/100 exactly; negative: 100t > P + 99.
  assign pct_sel  = flags_u.latched ? off_pct_i : on_pct_i;
  assign range_w  = {pedal_max_i[VALUE_BITS-1], pedal_max_i}
                  - {pedal_min_i[VALUE_BITS-1], pedal_min_i};
  assign prod_w   = range_w * $signed({1'b0, pct_sel});
  assign prod_x   = CW'(prod_w);
  assign t100     = CW'(thr_u) * HUNDRED;
  assign above_th = prod_x[CW-1] ? (t100 > (prod_x + NINETY_NINE)) : (t100 > prod_x);

  // Latch, error handling and throttle report
  always_comb begin
    flags        = flags_u;
    lrep         = last_rep_i;
    cnt          = 2'd0;
    res_o[0]     = '0;
    res_o[1]     = '0;
    res_thr_o[0] = '0;
    res_thr_o[1] = '0;
    run = (flags_u.accel != ST_INIT) && (flags_u.brake != ST_INIT);
    io  = run && ((flags_u.accel == ST_ERR) || (flags_u.brake == ST_ERR));

    // hysteresis latch, normal operation only
    if (run && !io) begin
      if (flags.latched) begin
        if (!above_th) flags.latched = 1'b0;
      end else if (above_th && flags.brake_pressed) begin
        flags.latched = 1'b1;
      end
    end

    if (io) begin
      req = ERR_IO;
    end else if (run && flags.latched) begin
      req = ERR_PLAUS;
    end else begin
      req = ERR_NONE;
    end

    if (run) begin
      if ((flags.active == ERR_NONE) && (req != ERR_NONE)) begin
        // zero report first unless zero already stands reported
        if (!(flags.last_valid && (lrep == '0))) begin
          res_o[cnt[0]].kind = KIND_REPORT;
          res_thr_o[cnt[0]]  = '0;
          cnt                = cnt + 2'd1;
        end
        flags.last_valid         = 1'b0;
        res_o[cnt[0]].kind       = KIND_ASSERT;
        res_o[cnt[0]].error_kind = (req == ERR_PLAUS) ? EK_PLAUS : EK_IO;
        cnt                      = cnt + 2'd1;
        flags.active             = req;
      end else if ((flags.active != ERR_NONE) && (req == ERR_NONE)) begin
        res_o[cnt[0]].kind       = KIND_RELEASE;
        res_o[cnt[0]].error_kind = (flags.active == ERR_PLAUS) ? EK_PLAUS : EK_IO;
        cnt                      = cnt + 2'd1;
        flags.active             = ERR_NONE;
      end
    end

    // deduplicated throttle report
    if (run && !io && !flags.latched && (!flags.last_valid || (lrep != thr_u))) begin
      res_o[cnt[0]].kind = KIND_REPORT;
      res_thr_o[cnt[0]]  = thr_u;
      cnt                = cnt + 2'd1;
      lrep               = thr_u;
      flags.last_valid   = 1'b1;
    end

    if (cnt != 2'd0) begin
      res_o[cnt[0] ^ 1'b1].last = 1'b1;
    end
  end

  assign flags_o    = flags;
  assign thr_o      = thr_u;
  assign last_rep_o = lrep;
  assign res_cnt_o  = cnt;

endmodule

`default_nettype wire

// ===== rtl/pedal_plausibility_monitor.sv =====
// ----------------------------------------------------------------------------
// pedal_plausibility_monitor
// Accelerator / brake plausibility check with throttle reporting and error
// assert / release events.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Content
//  s_axis    in         s_axis_tvalid/tready      pedal event
//  m_axis    out        m_axis_tvalid/tready      report / error event, tlast
//  cfg       in         cfg_valid_i/cfg_ready_o   register index and data
//
//  One event per cycle enters an input register while s_axis_tready is high;
//  the single-pass evaluation moves it into a two-slot result buffer, from
//  which its results go out. Output drains one result per cycle while
//  m_axis_tready is high; an event with two results needs the buffer empty or
//  emptying, so directly behind another pair it waits in the input register.
//  Asynchronous active-low reset; no clearing pass. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pedal_plausibility_monitor #(
  parameter int unsigned VALUE_BITS = 16,
  localparam int unsigned IN_DW  = ((VALUE_BITS + 8) / 8) * 8,
  localparam int unsigned OUT_DW = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // event input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DW-1:0]      s_axis_tdata,   // sample_value, error_flag
  input  logic [2:0]            s_axis_tuser,   // source, op[1:0]
  // result output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DW-1:0]     m_axis_tdata,   // throttle
  output logic [2:0]            m_axis_tuser,   // kind[1:0], error_kind
  output logic                  m_axis_tlast,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_addr_i,
  input  logic [VALUE_BITS-1:0] cfg_data_i
);
  import ppm_pkg::*;

  typedef struct packed {
    ppm_res_t                     ctl;
    logic signed [VALUE_BITS-1:0] thr;
  } out_slot_t;

  localparam ppm_flags_t FLAGS_RESET = '{
    accel: ST_INIT, brake: ST_INIT, active: ERR_NONE,
    brake_pressed: 1'b0, latched: 1'b0, last_valid: 1'b0
  };

  // configuration registers
  logic signed [VALUE_BITS-1:0] pmin_q, pmax_q;
  logic [PCT_W-1:0]             on_pct_q, off_pct_q;

  // input register
  logic                         in_vld_q, in_vld_d;
  logic                         in_src_q;
  logic [1:0]                   in_op_q;
  logic signed [VALUE_BITS-1:0] in_smp_q;
  logic                         in_ef_q;
  logic                         s_acc;

  // monitor state
  ppm_flags_t                   flags_q, flags_d;
  logic signed [VALUE_BITS-1:0] thr_q, thr_d;
  logic signed [VALUE_BITS-1:0] lrep_q, lrep_d;

  // evaluation results
  logic [1:0]                   res_cnt;
  ppm_res_t                     res [2];
  logic signed [VALUE_BITS-1:0] res_thr [2];

  // result buffer
  out_slot_t                    slot_q [2];
  out_slot_t                    slot_d [2];
  logic [1:0]                   cnt_q, cnt_d;
  logic [1:0]                   rem;
  logic                         pop;
  logic                         process;

  // Configuration write port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmin_q    <= '0;
      pmax_q    <= VALUE_BITS'(PEDAL_MAX_RESET);
      on_pct_q  <= ON_PCT_RESET;
      off_pct_q <= OFF_PCT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        CFG_PEDAL_MIN: pmin_q    <= cfg_data_i;
        CFG_PEDAL_MAX: pmax_q    <= cfg_data_i;
        CFG_ON_PCT:    on_pct_q  <= cfg_data_i[PCT_W-1:0];
        CFG_OFF_PCT:   off_pct_q <= cfg_data_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: loads when empty or as the held event moves on
  assign s_axis_tready = !in_vld_q || process;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (s_acc) begin
      in_vld_d = 1'b1;
    end else if (process) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_src_q <= s_axis_tuser[0];
      in_op_q  <= s_axis_tuser[2:1];
      in_smp_q <= s_axis_tdata[VALUE_BITS-1:0];
      in_ef_q  <= s_axis_tdata[VALUE_BITS];
    end
  end

  // Event evaluation
  ppm_eval #(
    .VALUE_BITS (VALUE_BITS)
  ) u_eval (
    .src_i       (in_src_q),
    .op_i        (in_op_q),
    .sample_i    (in_smp_q),
    .err_flag_i  (in_ef_q),
    .pedal_min_i (pmin_q),
    .pedal_max_i (pmax_q),
    .on_pct_i    (on_pct_q),
    .off_pct_i   (off_pct_q),
    .flags_i     (flags_q),
    .thr_i       (thr_q),
    .last_rep_i  (lrep_q),
    .flags_o     (flags_d),
    .thr_o       (thr_d),
    .last_rep_o  (lrep_d),
    .res_cnt_o   (res_cnt),
    .res_o       (res),
    .res_thr_o   (res_thr)
  );

  // State commits when the event's results fit in the buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= FLAGS_RESET;
      thr_q   <= '0;
      lrep_q  <= '0;
    end else if (process) begin
      flags_q <= flags_d;
      thr_q   <= thr_d;
      lrep_q  <= lrep_d;
    end
  end

  // Result buffer: pop head, shift, append new results behind survivors
  assign pop     = (cnt_q != 2'd0) && m_axis_tready;
  assign rem     = pop ? (cnt_q - 2'd1) : cnt_q;
  assign process = in_vld_q && ({1'b0, res_cnt} <= (3'd2 - {1'b0, rem}));

  always_comb begin
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    cnt_d     = rem;
    if (pop) begin
      slot_d[0] = slot_q[1];
    end
    if (process) begin
      if (rem == 2'd0) begin
        slot_d[0] = '{ctl: res[0], thr: res_thr[0]};
        slot_d[1] = '{ctl: res[1], thr: res_thr[1]};
      end else if (rem == 2'd1) begin
        slot_d[1] = '{ctl: res[0], thr: res_thr[0]};
      end
      cnt_d = rem + res_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

  // Output port
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tlast  = slot_q[0].ctl.last;
  assign m_axis_tuser  = {slot_q[0].ctl.error_kind, slot_q[0].ctl.kind};

  always_comb begin
    m_axis_tdata                   = '0;
    m_axis_tdata[VALUE_BITS-1:0]   = slot_q[0].thr;
  end

  // Checks
  `PPM_ASSERT(a_latch_has_error, clk_i, rst_ni, flags_q.latched |-> flags_q.active != ERR_NONE, "plausibility latch set with no active error")
  `PPM_ASSERT(a_pair_buffered, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tlast) |-> cnt_q == 2'd2, "first of a result pair without its partner")
  `PPM_ASSERT(a_empty_takes_event, clk_i, rst_ni, (in_vld_q && cnt_q == 2'd0) |-> process, "held event stalled with an empty result buffer")
  `PPM_ASSERT_NEXT(a_result_shows, clk_i, rst_ni, process && res_cnt != 2'd0, cnt_q != 2'd0, "results of an event were not buffered")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedal plausibility monitor testbench
// Drives accelerator and brake events into the monitor and checks every
// throttle report and error assert / release against a cycle-free predictor
// kept alongside the stimulus. Covers a directed sequence, several threshold
// settings, output back-pressure, drain pauses and back-to-back traffic.
// ----------------------------------------------------------------------------
module testbench;
  import ppm_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int END_GUARD    = 5000;

  // Unrelated-event opcodes (the package names only sample and error)
  localparam logic [1:0] OP_OTHER = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] throttle;
    logic               error_kind;
    logic               last;
  } monitor_event_t;

  // DUT connections
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // sample_value[15:0], error_flag[16]
  logic [2:0]  s_axis_tuser  = '0;   // source[0], op[2:1]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // throttle[15:0]
  logic [2:0]  m_axis_tuser;         // kind[1:0], error_kind[2]
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i    = '0;
  logic [15:0] cfg_data_i    = '0;

  // Traffic shaping
  logic rx_hold   = 1'b0;
  logic rx_steady = 1'b0;
  bit   tx_steady = 1'b0;
  int   mismatches = 0;

  // Predicted monitor state and configuration
  status_e            accel_st   = ST_INIT;
  status_e            brake_st   = ST_INIT;
  err_e               active_err = ERR_NONE;
  logic signed [15:0] thr_rd     = '0;
  logic signed [15:0] last_rep   = '0;
  logic               brake_on   = 1'b0;
  logic               latched    = 1'b0;
  logic               rep_valid  = 1'b0;
  logic signed [15:0] cfg_min    = 16'sd0;
  logic signed [15:0] cfg_max    = 16'sd32767;
  logic [6:0]         cfg_on     = ON_PCT_RESET;
  logic [6:0]         cfg_off    = OFF_PCT_RESET;

  monitor_event_t events_due[$];
  monitor_event_t item_events[$];
  monitor_event_t due;

  pedal_plausibility_monitor #(
    .VALUE_BITS(16)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 200) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void push_event(input logic [1:0] kind, input logic signed [15:0] thr,
                                     input logic ek);
    monitor_event_t ev;
    ev.kind       = kind;
    ev.throttle   = thr;
    ev.error_kind = ek;
    ev.last       = 1'b0;
    item_events.push_back(ev);
  endfunction

  function automatic void request_error(input err_e req);
    if (active_err == ERR_NONE && req != ERR_NONE) begin
      // a zero throttle goes out first unless zero is already the last report
      if (!(rep_valid && last_rep == 16'sd0)) push_event(KIND_REPORT, 16'sd0, EK_IO);
      rep_valid = 1'b0;
      push_event(KIND_ASSERT, 16'sd0, (req == ERR_PLAUS) ? EK_PLAUS : EK_IO);
      active_err = req;
    end else if (active_err != ERR_NONE && req == ERR_NONE) begin
      push_event(KIND_RELEASE, 16'sd0, (active_err == ERR_PLAUS) ? EK_PLAUS : EK_IO);
      active_err = ERR_NONE;
    end
  endfunction

  function automatic void evaluate_monitor();
    int span;
    int lim;
    if (accel_st == ST_INIT || brake_st == ST_INIT) return;
    if (accel_st == ST_ERR || brake_st == ST_ERR) begin
      request_error(ERR_IO);
      return;
    end
    // hysteresis on the plausibility latch
    span = int'(cfg_max) - int'(cfg_min);
    if (latched) begin
      lim = (span * int'(cfg_off)) / 100;
      if (int'(thr_rd) <= lim) latched = 1'b0;
    end else begin
      lim = (span * int'(cfg_on)) / 100;
      if (int'(thr_rd) > lim && brake_on) latched = 1'b1;
    end
    request_error(latched ? ERR_PLAUS : ERR_NONE);
    if (!latched && (!rep_valid || last_rep != thr_rd)) begin
      push_event(KIND_REPORT, thr_rd, EK_IO);
      last_rep  = thr_rd;
      rep_valid = 1'b1;
    end
  endfunction

  function automatic void apply_event(input logic src, input logic [1:0] op,
                                      input logic signed [15:0] val, input logic ef);
    item_events.delete();
    if (op == OP_SAMPLE) begin
      if (src == SRC_ACCEL) begin
        accel_st = ST_NORMAL;
        thr_rd   = val;
      end else begin
        brake_st = ST_NORMAL;
        brake_on = (val > 16'sd0);
      end
    end else if (op == OP_ERROR && ef) begin
      if (src == SRC_ACCEL) accel_st = ST_ERR;
      else brake_st = ST_ERR;
    end
    evaluate_monitor();
    if (item_events.size() > 0) item_events[item_events.size() - 1].last = 1'b1;
    foreach (item_events[i]) events_due.push_back(item_events[i]);
  endfunction

  function automatic void store_register(input logic [1:0] addr, input logic [15:0] data);
    case (addr)
      CFG_PEDAL_MIN: cfg_min = data;
      CFG_PEDAL_MAX: cfg_max = data;
      CFG_ON_PCT:    cfg_on  = data[6:0];
      CFG_OFF_PCT:   cfg_off = data[6:0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checker and output ready
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (events_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result, kind %0d throttle %0d",
                                  m_axis_tuser[1:0], $signed(m_axis_tdata)));
      end else begin
        due = events_due.pop_front();
        if (m_axis_tuser[1:0] !== due.kind)
          report_mismatch($sformatf("kind got %0d, expected %0d", m_axis_tuser[1:0], due.kind));
        if (m_axis_tdata !== due.throttle)
          report_mismatch($sformatf("throttle got %0d, expected %0d",
                                    $signed(m_axis_tdata), due.throttle));
        if (m_axis_tuser[2] !== due.error_kind)
          report_mismatch($sformatf("error kind got %0d, expected %0d",
                                    m_axis_tuser[2], due.error_kind));
        if (m_axis_tlast !== due.last)
          report_mismatch($sformatf("tlast got %0d, expected %0d", m_axis_tlast, due.last));
      end
    end
    m_axis_tready <= !rx_hold && (rx_steady || $urandom_range(0, 99) >= 24);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_event(input logic src, input logic [1:0] op,
                            input logic signed [15:0] val, input logic ef);
    int gap;
    gap = 0;
    while (!tx_steady && $urandom_range(0, 99) < 24) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, ef, val};
    s_axis_tuser  <= {op, src};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_event(src, op, val, ef);
  endtask

  // Waits until every predicted result is out, then lets in-flight items settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_thresholds(input logic signed [15:0] lo, input logic signed [15:0] hi,
                                 input logic [6:0] on_p, input logic [6:0] off_p);
    logic [1:0]  addr_list [4];
    logic [15:0] data_list [4];
    addr_list[0] = CFG_PEDAL_MIN;  data_list[0] = lo;
    addr_list[1] = CFG_PEDAL_MAX;  data_list[1] = hi;
    addr_list[2] = CFG_ON_PCT;     data_list[2] = {9'd0, on_p};
    addr_list[3] = CFG_OFF_PCT;    data_list[3] = {9'd0, off_p};
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_addr_i <= addr_list[i];
      cfg_data_i <= data_list[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      store_register(addr_list[i], data_list[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Throttle values often cluster around the current thresholds, with repeats, extremes and random values mixed in
  function automatic logic signed [15:0] pick_throttle();
    int span;
    int v;
    span = int'(cfg_max) - int'(cfg_min);
    case ($urandom_range(0, 9))
      0, 1, 2: v = (span * int'(cfg_on)) / 100 + int'($urandom_range(0, 6)) - 3;
      3, 4:    v = (span * int'(cfg_off)) / 100 + int'($urandom_range(0, 6)) - 3;
      5:       v = int'(thr_rd);
      6: begin
        case ($urandom_range(0, 2))
          0:       v = -32768;
          1:       v = 32767;
          default: v = 0;
        endcase
      end
      default: v = int'($signed(16'($urandom)));
    endcase
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] pick_brake();
    case ($urandom_range(0, 7))
      0:       return 16'sd0;
      1:       return 16'sd1;
      2:       return -16'sd1;
      3:       return 16'h8000;
      4:       return 16'h7fff;
      5:       return 16'($urandom);
      default: return 16'($urandom_range(1, 32767));
    endcase
  endfunction

  task automatic send_random_event();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      send_event(SRC_ACCEL, OP_SAMPLE, pick_throttle(), 1'($urandom_range(0, 1)));
    else if (pick < 78)
      send_event(SRC_BRAKE, OP_SAMPLE, pick_brake(), 1'($urandom_range(0, 1)));
    else if (pick < 88)
      send_event(1'($urandom_range(0, 1)), OP_ERROR, 16'($urandom), $urandom_range(0, 4) != 0);
    else
      send_event(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? OP_OTHER : OP_SPARE,
                 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_random(input int n);
    repeat (n) send_random_event();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Walk through the main state changes with reset thresholds
  task automatic test_directed_sequence();
    send_event(SRC_ACCEL, OP_OTHER,  16'sd0,      1'b0);  // both sensors still in init
    send_event(SRC_ACCEL, OP_ERROR,  16'sd0,      1'b1);  // error while brake in init
    send_event(SRC_ACCEL, OP_SAMPLE, 16'sd0,      1'b1);  // error flag ignored on sample
    send_event(SRC_BRAKE, OP_SAMPLE, 16'sd0,      1'b0);  // both normal: first report
    send_event(SRC_ACCEL, OP_SAMPLE, 16'sd32767,  1'b0);
    send_event(SRC_BRAKE, OP_SAMPLE, 16'sd1,      1'b0);  // latch sets, zero report first
    send_event(SRC_ACCEL, OP_SAMPLE, 16'sd10000,  1'b0);  // stays latched
    send_event(SRC_ACCEL, OP_SAMPLE, 16'sd1638,   1'b0);  // exactly at clear level
    send_event(SRC_BRAKE, OP_SAMPLE, -16'sd32768, 1'b0);  // negative brake: not pressed
    send_event(SRC_ACCEL, OP_SAMPLE, -16'sd32768, 1'b0);
    send_event(SRC_ACCEL, OP_SAMPLE, -16'sd32768, 1'b0);  // duplicate suppressed
    send_event(SRC_BRAKE, OP_ERROR,  16'sd0,      1'b0);  // error event without error
    send_event(SRC_BRAKE, OP_ERROR,  16'sd0,      1'b1);  // IO error asserted
    send_event(SRC_ACCEL, OP_SAMPLE, 16'sd500,    1'b0);  // IO error already active
    send_event(SRC_BRAKE, OP_SPARE,  16'sd0,      1'b0);  // spare opcode
    send_event(SRC_BRAKE, OP_SAMPLE, 16'sd0,      1'b0);  // IO error released
    send_event(SRC_ACCEL, OP_ERROR,  16'sd0,      1'b1);
    send_event(SRC_ACCEL, OP_SAMPLE, 16'sd0,      1'b0);  // report after invalidation
    send_event(SRC_BRAKE, OP_SAMPLE, 16'sd32767,  1'b0);
    send_event(SRC_ACCEL, OP_SAMPLE, 16'sd8191,   1'b0);  // exactly at set level
    send_event(SRC_ACCEL, OP_SAMPLE, 16'sd8192,   1'b0);  // just above set level
    send_event(SRC_ACCEL, OP_ERROR,  16'sd0,      1'b1);  // other kind requested
    send_event(SRC_ACCEL, OP_SAMPLE, 16'sd0,      1'b0);
    wait_drained();
  endtask

  // Threshold extremes, empty and inverted range, random settings
  task automatic test_threshold_settings();
    load_thresholds(-16'sd32768, 16'sd32767, 7'd100, 7'd0);
    run_random(110);
    wait_drained();
    load_thresholds(-16'sd32768, 16'sd32767, 7'd0, 7'd100);
    run_random(110);
    wait_drained();
    load_thresholds(16'sd32767, -16'sd32768, 7'd50, 7'd10);
    run_random(110);
    wait_drained();
    load_thresholds(16'sd100, 16'sd100, 7'd25, 7'd5);
    run_random(110);
    wait_drained();
    load_thresholds(16'sd0, 16'sd1000, 7'd25, 7'd5);
    run_random(110);
    wait_drained();
    load_thresholds(-16'sd1000, 16'sd4000, 7'd60, 7'd30);
    run_random(110);
    repeat (2) begin
      wait_drained();
      load_thresholds(16'($urandom), 16'($urandom), 7'($urandom_range(0, 100)),
                      7'($urandom_range(0, 100)));
      run_random(110);
    end
    wait_drained();
    load_thresholds(16'sd0, 16'sd32767, ON_PCT_RESET, OFF_PCT_RESET);
    run_random(110);
    wait_drained();
  endtask

  // Sender stops until all results are out, then resumes
  task automatic test_drain_pause();
    run_random(30);
    wait_drained();
    run_random(30);
    wait_drained();
  endtask

  // Output held off for a long stretch while events keep coming
  task automatic test_output_hold_off();
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      run_random(60);
    join
    wait_drained();
  endtask

  // No idling on either side
  task automatic test_back_to_back();
    tx_steady = 1'b1;
    rx_steady <= 1'b1;
    run_random(200);
    tx_steady = 1'b0;
    wait_drained();
    rx_steady <= 1'b0;
  endtask

  task automatic test_random_mix();
    run_random(100);
  endtask

  initial begin : stimulus
    int guard;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed_sequence();
    test_threshold_settings();
    test_drain_pause();
    test_output_hold_off();
    test_back_to_back();
    test_random_mix();
    // final drain
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (events_due.size() != 0 && guard < END_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (events_due.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", events_due.size()));
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== pedal_plausibility_monitor.f =====
+incdir+rtl
rtl/ppm_pkg.sv
rtl/ppm_eval.sv
rtl/pedal_plausibility_monitor.sv
sim/testbench.sv
